// File: hdl/wbwcd_pkg.sv
// Shared types and constants for the base-w digit splitter with checksum.
// Used by wbwcd_ram users, the top level and the port checker.
`timescale 1ns / 1ps

package wbwcd_pkg;

	localparam int MAX_MSG_DIGITS_DEF  = 128;
	localparam int MAX_CSUM_DIGITS_DEF = 16;

	localparam int TBL_W     = 4;   // stored log width
	localparam int BUF_W     = 16;  // bit buffer
	localparam int HELD_W    = 5;   // bits held counter
	localparam int CSUM_W    = 15;  // checksum register
	localparam int DIGIT_W   = 8;
	localparam int MAX_LOG_W = 8;

	localparam int MSG_CNT_RST  = 64;
	localparam int CSUM_CNT_RST = 3;

	typedef enum logic {
		OP_TABLE_WRITE = 1'b0,
		OP_MSG_BYTE    = 1'b1
	} op_t;

	typedef enum logic {
		REG_MSG_COUNT  = 1'b0,
		REG_CSUM_COUNT = 1'b1
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSG_RD,
		ST_MSG_CHK,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_CS_RD,
		ST_CS_EMIT
	} state_t;

	// clamp a stored width to 1..8
	function automatic logic [TBL_W-1:0] eff_width(input logic [TBL_W-1:0] raw);
		logic [TBL_W-1:0] w;
		w = raw;
		if (raw == '0)
			w = TBL_W'(1);
		else if (raw > TBL_W'(MAX_LOG_W))
			w = TBL_W'(MAX_LOG_W);
		return w;
	endfunction

	// (1 << w) - 1 for w in 1..8
	function automatic logic [DIGIT_W-1:0] width_mask(input logic [TBL_W-1:0] w);
		logic [DIGIT_W:0] m;
		m = (9'd1 << w) - 9'd1;
		return m[DIGIT_W-1:0];
	endfunction

endpackage

// File: hdl/wbwcd_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module wbwcd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 144,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/wots_base_w_checksum_digits_top.sv
// Top level of the base-w digit splitter with per-position widths and checksum.
// Depends on wbwcd_pkg and wbwcd_ram.
`timescale 1ns / 1ps
//
// Usage:
//  Input channel (in_valid/in_ready): op selects a width table write (entry_index,
//  log_width) or a message byte (data_byte, last_byte). Table writes give no
//  digits. A byte is cut MSB first into message digits, one digit per width
//  table position; a byte marked last is followed by the checksum digits
//  over positions M..M+C-1.
//  Output channel (out_valid/out_ready): one beat per digit, held in an output
//  register, so the sequencer keeps working while one digit waits.
//  Config channel (cfg_valid/cfg_ready, cfg_addr, cfg_data): always ready; write
//  only while idle. Index 0 is the message digit count, 1 the checksum count.
//  Timing: every table lookup goes through the single registered read port of
//  the width table: a read state, then a state that uses the width. A last
//  byte adds two passes over the C checksum positions (one to total the
//  widths, one to emit). in_ready is low while a byte is worked on. A byte is
//  loaded on accept, its width read in ST_MSG_RD, its digit registered in
//  ST_MSG_CHK. If the receiver stalls, the sequencer waits at the next digit.
//  Reset: counts go to 64 and 3, message state clears. The width table is not
//  cleared and must be written before its entries are used.

module wots_base_w_checksum_digits_top
	import wbwcd_pkg::*;
#(
	parameter int MAX_MSG_DIGITS  = MAX_MSG_DIGITS_DEF,
	parameter int MAX_CSUM_DIGITS = MAX_CSUM_DIGITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// config
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_addr,
	input  logic [7:0]   cfg_data,
	// input beats
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         op,
	input  logic [7:0]   entry_index,
	input  logic [3:0]   log_width,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	// output beats
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   digit_value,
	output logic [7:0]   digit_index,
	output logic         is_checksum,
	output logic         last_digit,
	output logic         short_message
);

	localparam int DEPTH = MAX_MSG_DIGITS + MAX_CSUM_DIGITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_n;

	logic [7:0]        msg_count_q;
	logic [4:0]        csum_count_q;
	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [7:0]        done_q;
	logic [CSUM_W-1:0] csum_q;
	logic [7:0]        total_q;
	logic [7:0]        rem_q;
	logic [4:0]        j_q;
	logic              last_q;

	logic              out_valid_q;
	logic [7:0]        digit_value_q;
	logic [7:0]        digit_index_q;
	logic              is_checksum_q;
	logic              last_digit_q;
	logic              short_q;

	logic [7:0]        m_eff;
	logic [4:0]        c_eff;
	logic              quota_open;
	logic              slot_free;
	logic              in_acc;
	logic [7:0]        cs_pos;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [TBL_W-1:0]  ram_rdata;
	logic [TBL_W-1:0]  w;
	logic [DIGIT_W-1:0] mask;
	logic [HELD_W-1:0] held_n;
	logic [DIGIT_W-1:0] msg_digit;
	logic [7:0]        rem_n;
	logic [DIGIT_W-1:0] cs_digit;
	logic              j_is_last;

	// strobes
	logic load_byte, take_msg, start_sum, sum_acc, take_cs, clr_msg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_count_q  <= 8'(MSG_CNT_RST);
			csum_count_q <= 5'(CSUM_CNT_RST);
		end else if (cfg_valid) begin
			unique case (reg_t'(cfg_addr))
				REG_MSG_COUNT:  msg_count_q  <= cfg_data;
				REG_CSUM_COUNT: csum_count_q <= cfg_data[4:0];
			endcase
		end
	end

	always_comb begin
		m_eff = msg_count_q;
		if (msg_count_q == '0)
			m_eff = 8'd1;
		else if (msg_count_q > 8'(MAX_MSG_DIGITS))
			m_eff = 8'(MAX_MSG_DIGITS);
		c_eff = csum_count_q;
		if (csum_count_q == '0)
			c_eff = 5'd1;
		else if (csum_count_q > 5'(MAX_CSUM_DIGITS))
			c_eff = 5'(MAX_CSUM_DIGITS);
	end

	assign quota_open = done_q < m_eff;
	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign cs_pos     = m_eff + 8'(j_q);
	assign j_is_last  = (j_q + 5'd1) == c_eff;

	// width table
	assign ram_we = in_acc && (op_t'(op) == OP_TABLE_WRITE) && (entry_index < 8'(DEPTH));

	wbwcd_ram #(
		.WIDTH(TBL_W),
		.DEPTH(DEPTH)
	) u_width_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index[AW-1:0]),
		.wdata (log_width),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared digit datapath
	assign w         = eff_width(ram_rdata);
	assign mask      = width_mask(w);
	assign held_n    = held_q - HELD_W'(w);
	assign msg_digit = DIGIT_W'(buf_q >> held_n) & mask;
	assign rem_n     = rem_q - 8'(w);
	assign cs_digit  = DIGIT_W'(csum_q >> rem_n) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		ram_re    = 1'b0;
		ram_raddr = cs_pos[AW-1:0];
		load_byte = 1'b0;
		take_msg  = 1'b0;
		start_sum = 1'b0;
		sum_acc   = 1'b0;
		take_cs   = 1'b0;
		clr_msg   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op_t'(op) == OP_MSG_BYTE) begin
					if (quota_open) begin
						load_byte = 1'b1;
						state_n   = ST_MSG_RD;
					end else if (last_byte) begin
						start_sum = 1'b1;
						state_n   = ST_SUM_RD;
					end
				end
			end
			ST_MSG_RD: begin
				if (quota_open) begin
					ram_re    = 1'b1;
					ram_raddr = done_q[AW-1:0];
					state_n   = ST_MSG_CHK;
				end else if (last_q) begin
					start_sum = 1'b1;
					state_n   = ST_SUM_RD;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_MSG_CHK: begin
				if (held_q < HELD_W'(w)) begin
					// not enough bits for this position: wait for next byte, or start the checksum after a last byte
					if (last_q) begin
						start_sum = 1'b1;
						state_n   = ST_SUM_RD;
					end else begin
						state_n = ST_IDLE;
					end
				end else if (slot_free) begin
					take_msg = 1'b1;
					state_n  = ST_MSG_RD;
				end
			end
			ST_SUM_RD: begin
				ram_re  = 1'b1;
				state_n = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				sum_acc = 1'b1;
				state_n = j_is_last ? ST_CS_RD : ST_SUM_RD;
			end
			ST_CS_RD: begin
				ram_re  = 1'b1;
				state_n = ST_CS_EMIT;
			end
			ST_CS_EMIT: begin
				if (slot_free) begin
					take_cs = 1'b1;
					if (j_is_last) begin
						clr_msg = 1'b1;
						state_n = ST_IDLE;
					end else begin
						state_n = ST_CS_RD;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			held_q  <= '0;
			done_q  <= '0;
			csum_q  <= '0;
			total_q <= '0;
			rem_q   <= '0;
			j_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			if (in_acc)
				last_q <= last_byte;
			if (load_byte) begin
				buf_q  <= {buf_q[BUF_W-9:0], data_byte};
				held_q <= held_q + HELD_W'(8);
			end
			if (take_msg) begin
				held_q <= held_n;
				done_q <= done_q + 8'd1;
				csum_q <= csum_q + CSUM_W'(mask - msg_digit);
			end
			if (start_sum) begin
				j_q     <= '0;
				total_q <= '0;
			end
			if (sum_acc) begin
				if (j_is_last) begin
					j_q   <= '0;
					rem_q <= total_q + 8'(w);
				end else begin
					j_q     <= j_q + 5'd1;
					total_q <= total_q + 8'(w);
				end
			end
			if (take_cs) begin
				j_q   <= j_q + 5'd1;
				rem_q <= rem_n;
			end
			if (clr_msg) begin
				buf_q  <= '0;
				held_q <= '0;
				done_q <= '0;
				csum_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take_msg || take_cs)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_msg) begin
			digit_value_q <= msg_digit;
			digit_index_q <= done_q;
			is_checksum_q <= 1'b0;
			last_digit_q  <= 1'b0;
			short_q       <= 1'b0;
		end else if (take_cs) begin
			digit_value_q <= cs_digit;
			digit_index_q <= cs_pos;
			is_checksum_q <= 1'b1;
			last_digit_q  <= j_is_last;
			short_q       <= quota_open;
		end
	end

	assign out_valid     = out_valid_q;
	assign digit_value   = digit_value_q;
	assign digit_index   = digit_index_q;
	assign is_checksum   = is_checksum_q;
	assign last_digit    = last_digit_q;
	assign short_message = short_q;

endmodule

// File: hdl/wbwcd_chk.sv
// Port-level checker for wots_base_w_checksum_digits_top, bound to the top level.
// Depends on wbwcd_pkg.
`timescale 1ns / 1ps

module wbwcd_chk
	import wbwcd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] digit_value,
	input logic [7:0] digit_index,
	input logic       is_checksum,
	input logic       last_digit,
	input logic       short_message
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_value) && $stable(digit_index))
		else $error("output beat changed while stalled");

	a_last_is_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_digit |-> is_checksum)
		else $error("last_digit on a message digit");

	a_msg_not_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_checksum |-> !short_message)
		else $error("short_message on a message digit");

	// checksum positions follow at least one message position
	a_cs_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_checksum |-> digit_index != 8'd0)
		else $error("checksum digit at position zero");

	// the input is ready again in the cycle after a table write
	a_tbl_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op_t'(op) == OP_TABLE_WRITE |=> in_ready)
		else $error("not ready after table write");

endmodule

bind wots_base_w_checksum_digits_top wbwcd_chk u_wbwcd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.op            (op),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.digit_value   (digit_value),
	.digit_index   (digit_index),
	.is_checksum   (is_checksum),
	.last_digit    (last_digit),
	.short_message (short_message)
);

// File: tb/digit_stream_checker.sv
// Scoreboard for wots_base_w_checksum_digits_top: tracks width table, counts and
// message state from the accepted beats, predicts each digit and checks it in order.
// Depends on wbwcd_pkg.
`timescale 1ns / 1ps

module digit_stream_checker
	import wbwcd_pkg::*;
#(
	parameter int MSG_MAX  = MAX_MSG_DIGITS_DEF,
	parameter int CSUM_MAX = MAX_CSUM_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_addr,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       op,
	input  logic [7:0] entry_index,
	input  logic [3:0] log_width,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] digit_value,
	input  logic [7:0] digit_index,
	input  logic       is_checksum,
	input  logic       last_digit,
	input  logic       short_message,
	output int         fail_count,
	output int         pending
);

	localparam int DEPTH = MSG_MAX + CSUM_MAX;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] index;
		logic       csum;
		logic       last;
		logic       shrt;
	} digit_t;

	digit_t      digits_due[$];
	logic [3:0]  widths [DEPTH];
	logic [7:0]  msg_count;
	logic [4:0]  csum_count;
	int unsigned bit_store;
	int unsigned bits_in;
	int unsigned digits_taken;
	int unsigned csum_acc;

	function automatic int unsigned width_at(int unsigned pos);
		int unsigned w;
		w = widths[pos];
		if (w == 0)
			w = 1;
		else if (w > MAX_LOG_W)
			w = MAX_LOG_W;
		return w;
	endfunction

	task automatic report_mismatch(string what, int pos, int got, int want);
		$display("ERROR %0t: digit %0d %s got %0d, expected %0d", $time, pos, what, got, want);
		fail_count++;
	endtask

	task automatic queue_digit(int unsigned val, int unsigned pos, logic cs, logic lst,
			logic sh);
		digit_t e;
		e.value = val[7:0];
		e.index = pos[7:0];
		e.csum  = cs;
		e.last  = lst;
		e.shrt  = sh;
		digits_due.push_back(e);
	endtask

	task automatic predict_digits(logic o, logic [7:0] idx, logic [3:0] lw,
			logic [7:0] byte_in, logic lst);
		int unsigned m, c, b, mask, d, total, rem, j;
		logic shrt;
		if (op_t'(o) == OP_TABLE_WRITE) begin
			if (idx < DEPTH)
				widths[idx] = lw;
			return;
		end
		m = (msg_count == 0) ? 1 : ((msg_count > MSG_MAX) ? MSG_MAX : msg_count);
		c = (csum_count == 0) ? 1 : ((csum_count > CSUM_MAX) ? CSUM_MAX : csum_count);
		// past the quota the byte is dropped, only a last flag still counts
		if (digits_taken < m) begin
			bit_store = ((bit_store << 8) | byte_in) & 32'hFFFF;
			bits_in += 8;
			while (digits_taken < m && bits_in >= width_at(digits_taken)) begin
				b = width_at(digits_taken);
				bits_in -= b;
				mask = (1 << b) - 1;
				d = (bit_store >> bits_in) & mask;
				csum_acc = (csum_acc + mask - d) & 32'h7FFF;
				queue_digit(d, digits_taken, 1'b0, 1'b0, 1'b0);
				digits_taken++;
			end
			bit_store &= (1 << bits_in) - 1;
		end
		if (lst) begin
			shrt = digits_taken < m;
			total = 0;
			for (j = 0; j < c; j++)
				total += width_at(m + j);
			rem = total;
			// checksum digits MSB first; bits beyond the register read as zero
			for (j = 0; j < c; j++) begin
				b = width_at(m + j);
				rem -= b;
				d = (rem < 32) ? ((csum_acc >> rem) & ((1 << b) - 1)) : 0;
				queue_digit(d, m + j, 1'b1, j + 1 == c, shrt);
			end
			bit_store = 0;
			bits_in = 0;
			digits_taken = 0;
			csum_acc = 0;
		end
	endtask

	task automatic check_digit();
		digit_t want;
		if (digits_due.size() == 0) begin
			report_mismatch("arrived with none pending, value", digit_index, digit_value, -1);
			return;
		end
		want = digits_due.pop_front();
		if (digit_value !== want.value)
			report_mismatch("digit_value", want.index, digit_value, want.value);
		if (digit_index !== want.index)
			report_mismatch("digit_index", want.index, digit_index, want.index);
		if (is_checksum !== want.csum)
			report_mismatch("is_checksum", want.index, is_checksum, want.csum);
		if (last_digit !== want.last)
			report_mismatch("last_digit", want.index, last_digit, want.last);
		if (short_message !== want.shrt)
			report_mismatch("short_message", want.index, short_message, want.shrt);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_due.delete();
			for (int k = 0; k < DEPTH; k++)
				widths[k] = '0;
			msg_count = 8'(MSG_CNT_RST);
			csum_count = 5'(CSUM_CNT_RST);
			bit_store = 0;
			bits_in = 0;
			digits_taken = 0;
			csum_acc = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (reg_t'(cfg_addr) == REG_MSG_COUNT)
					msg_count = cfg_data;
				else
					csum_count = cfg_data[4:0];
			end
			// an output beat never stems from an input beat of the same edge
			if (out_valid && out_ready)
				check_digit();
			if (in_valid && in_ready)
				predict_digits(op, entry_index, log_width, data_byte, last_byte);
			pending = digits_due.size();
		end
	end

endmodule

// File: tb/tb_wots_base_w_checksum_digits_top.sv
// Testbench top for wots_base_w_checksum_digits_top: clock, reset, directed and
// random beats on all three channels, idle/stall phases and the verdict.
// Depends on wbwcd_pkg, the DUT and digit_stream_checker.
`timescale 1ns / 1ps

module tb_wots_base_w_checksum_digits_top;
	import wbwcd_pkg::*;

	localparam int DEPTH       = MAX_MSG_DIGITS_DEF + MAX_CSUM_DIGITS_DEF;
	localparam int LOW_POS     = 32;
	localparam int TAIL_CYCLES = 120;
	localparam int CYCLE_LIMIT = 900000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 13;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_addr = REG_MSG_COUNT;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = OP_TABLE_WRITE;
	logic [7:0] entry_index = '0;
	logic [3:0] log_width = '0;
	logic [7:0] data_byte = '0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] digit_value;
	logic [7:0] digit_index;
	logic       is_checksum;
	logic       last_digit;
	logic       short_message;
	int         fail_count;
	int         pending;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_cycles = 0;
	int cycles = 0;
	int eff_m = MSG_CNT_RST;
	int tb_widths [DEPTH];

	wots_base_w_checksum_digits_top DUT (.*);

	digit_stream_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off counted here
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("wots_base_w_checksum_digits_top regression: fail");
		$finish;
	end

	task automatic push_beat(op_t o, logic [7:0] idx, logic [3:0] lw, logic [7:0] dbyte,
			logic lst);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op = o;
		entry_index = idx;
		log_width = lw;
		data_byte = dbyte;
		last_byte = lst;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put_width(int idx, int lw);
		push_beat(OP_TABLE_WRITE, idx[7:0], lw[3:0], 8'($urandom_range(255)),
			1'($urandom_range(1)));
		if (idx < DEPTH)
			tb_widths[idx] = lw;
	endtask

	task automatic put_byte(logic [7:0] b, logic lst);
		push_beat(OP_MSG_BYTE, 8'($urandom_range(255)), 4'($urandom_range(15)), b, lst);
	endtask

	// wait out every pending digit, then the block's worst case per beat
	task automatic drain_digits();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(reg_t r, int v);
		drain_digits();
		cfg_addr = r;
		cfg_data = v[7:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (r == REG_MSG_COUNT)
			eff_m = (v == 0) ? 1 : ((v > MAX_MSG_DIGITS_DEF) ? MAX_MSG_DIGITS_DEF : v);
	endtask

	initial begin
		int i, ph, sent, bits, need, len, shape, mc, cc;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// low message positions and all checksum positions of the largest
		// quota get a width before any lookup can reach them
		for (i = 0; i < LOW_POS; i++)
			put_width(i, $urandom_range(15));
		for (i = MAX_MSG_DIGITS_DEF; i < DEPTH; i++)
			put_width(i, $urandom_range(15));

		// directed
		write_count(REG_MSG_COUNT, 3);
		write_count(REG_CSUM_COUNT, 2);
		put_width(0, 0);
		put_width(1, 15);
		put_width(2, 8);
		put_width(3, 1);
		put_width(4, 4);
		put_width(144, 3);
		put_width(255, 5);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b1);
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h5A, 1'b0);
		put_byte(8'hC3, 1'b1);
		// quota shrinks under a started message; checksum spans 16 bits
		put_byte(8'hA5, 1'b0);
		write_count(REG_MSG_COUNT, 1);
		put_byte(8'h3C, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					mc = 1;
					cc = 1;
				end
				1: begin
					mc = 128;
					cc = 16;
				end
				2: begin
					mc = 0;
					cc = 0;
				end
				3: begin
					mc = 255;
					cc = 31;
				end
				default: begin
					mc = $urandom_range(12, 1);
					cc = $urandom_range(16, 1);
				end
			endcase
			write_count(REG_MSG_COUNT, mc);
			write_count(REG_CSUM_COUNT, cc);
			@(posedge clk);
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 56;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 56;
				end
				default: begin
					src_idle_pct = 34;
					sink_stall_pct = 34;
				end
			endcase
			if (ph == 5)
				hold_cycles = 400;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 12) begin
					put_width($urandom_range(255), $urandom_range(15));
					sent++;
				end else if (eff_m > LOW_POS) begin
					// long quota: short messages stay within the low positions
					len = $urandom_range(2, 1);
					for (i = 0; i < len; i++)
						put_byte(8'($urandom_range(255)), i == len - 1);
					sent += len;
				end else begin
					bits = 0;
					for (i = 0; i < eff_m; i++)
						bits += (tb_widths[i] == 0) ? 1 : ((tb_widths[i] > 8) ? 8 : tb_widths[i]);
					need = (bits + 7) / 8;
					shape = $urandom_range(9);
					if (shape == 7)
						len = (need > 1) ? $urandom_range(need - 1, 1) : 1;
					else if (shape >= 8)
						len = need + $urandom_range(3, 1);
					else
						len = need;
					for (i = 0; i < len; i++)
						put_byte(8'($urandom_range(255)), i == len - 1);
					sent += len;
				end
			end
		end

		drain_digits();
		if (fail_count == 0)
			$display("wots_base_w_checksum_digits_top regression: pass");
		else
			$display("wots_base_w_checksum_digits_top regression: fail");
		$finish;
	end

endmodule
